// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of the ray marcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define GRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define GRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Shared constants, codes and types of the grid ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int SCREEN_COLUMNS_DEF = 640;
  localparam int GRID_SIZE_DEF      = 32;
  localparam int MAX_STEPS_DEF      = 512;

  // Divider numerator width: column * fov and screen_height << 10 both fit.
  localparam int NUM_W = 22;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FOV    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_H  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARK   = 3'd5;

  localparam logic [1:0] MODE_CAST  = 2'd0;
  localparam logic [1:0] MODE_SHOT  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } div_req_t;

endpackage

// ===== sv/grid_ray_march.sv =====
// ----------------------------------------------------------------------------
// grid_ray_march
// Fixed-step ray marcher over a grid of 3-bit tile codes with shot marking.
// ----------------------------------------------------------------------------
// Sequence: a write word is answered from idle. A cast hit runs the column angle,
//   the steps (advance, bounds check with grid read, tile test) and the wall
//   height divide, a shot hit all but the column angle. A miss skips the divide.
// Throughput: one word at a time; the next input is taken once the result
//   word has left. The step loop (up to MAX_STEPS) and the divider set it.
// Reset: control and config registers take defaults, then a clearing pass
//   over all GRID_SIZE*GRID_SIZE cells zeroes the grid while input is stalled.
// ----------------------------------------------------------------------------
module grid_ray_march #(
  parameter int SCREEN_COLUMNS = grm_pkg::SCREEN_COLUMNS_DEF,
  parameter int GRID_SIZE      = grm_pkg::GRID_SIZE_DEF,
  parameter int MAX_STEPS      = grm_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [grm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [14:0]                   pos_x_i,
  input  logic [14:0]                   pos_y_i,
  input  logic [11:0]                   view_angle_i,
  input  logic [9:0]                    column_i,
  input  logic [4:0]                    cell_x_i,
  input  logic [4:0]                    cell_y_i,
  input  logic [2:0]                    cell_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [4:0]                    hit_x_o,
  output logic [4:0]                    hit_y_o,
  output logic [2:0]                    hit_value_o,
  output logic [15:0]                   distance_o,
  output logic [11:0]                   wall_height_o
);
  import grm_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(MAX_STEPS * 1023 + 1);
  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int FW    = DW + 17;
  localparam int CMW   = (FW - 25 > 7) ? FW - 25 : 7;
  localparam logic [6:0] GRID_LIM = 7'(GRID_SIZE);
  // Reciprocal of the column count, exact for every numerator below 2^NUM_W.
  localparam int RS = NUM_W + $clog2(SCREEN_COLUMNS);
  localparam logic [NUM_W:0] RECIP = (NUM_W+1)'(((64'd1 << RS) + 64'(SCREEN_COLUMNS)
                                                 - 64'd1) / 64'(SCREEN_COLUMNS));

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_DIVA  = 11'b00000000100,
    ST_SINX  = 11'b00000001000,
    ST_SINY  = 11'b00000010000,
    ST_MULX  = 11'b00000100000,
    ST_MULY  = 11'b00001000000,
    ST_STEP  = 11'b00010000000,
    ST_CHECK = 11'b00100000000,
    ST_READ  = 11'b01000000000,
    ST_DIVW  = 11'b10000000000
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [11:0] fov_q, scrh_q;
  logic [9:0]  step_q;
  logic [5:0]  mapw_q, maph_q;
  logic [2:0]  mark_q;

  // Item context.
  logic [1:0]  mode_q;
  logic [14:0] px_q, py_q;
  logic [11:0] view_q, ang_q;
  logic [NUM_W-1:0] numa_q;
  logic signed [15:0] dx_q, dy_q;
  logic signed [FW-1:0] ddx_q, ddy_q, fx_q, fy_q;
  logic [DW-1:0] dist_q;
  logic [SW-1:0] cnt_q;
  logic [AW-1:0] addr_q, clr_q;
  logic [4:0]    cx_q, cy_q;
  logic [2:0]    val_q;

  // Result word.
  logic        out_valid_q, hit_q;
  logic [4:0]  hx_q, hy_q;
  logic [2:0]  hv_q;
  logic [15:0] dist_out_q;
  logic [11:0] wall_q;

  // Grid memory.
  logic [2:0]    grid_mem [CELLS];
  logic [2:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [2:0]    mem_wd;

  logic            in_acc, out_acc;
  logic            wr_in_range;
  logic [11:0]     rom_ang;
  logic signed [15:0] rom_sin;
  div_req_t        div_req;
  logic [DW-1:0]   div_den;
  logic            div_done;
  logic [NUM_W-1:0] div_quot;
  logic [6:0]      lim_w, lim_h;
  logic            oob;
  logic [AW-1:0]   cell_addr;
  logic signed [26:0] prod;
  logic [2*NUM_W:0] share_prod;

  assign in_stall_o = (state_q != ST_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign wr_in_range = ({2'b0, cell_x_i} < GRID_LIM) && ({2'b0, cell_y_i} < GRID_LIM);

  // Map limits capped at the grid size.
  assign lim_w = ({1'b0, mapw_q} < GRID_LIM) ? {1'b0, mapw_q} : GRID_LIM;
  assign lim_h = ({1'b0, maph_q} < GRID_LIM) ? {1'b0, maph_q} : GRID_LIM;

  // Negative point or cell past the map: the ray has left the grid.
  assign oob = fx_q[FW-1] || fy_q[FW-1]
            || (CMW'(fx_q[FW-2:24]) >= CMW'(lim_w))
            || (CMW'(fy_q[FW-2:24]) >= CMW'(lim_h));

  assign cell_addr = AW'(int'(fy_q[30:24]) * GRID_SIZE + int'(fx_q[30:24]));

  // Cosine first, sine on the next cycle.
  assign rom_ang = (state_q == ST_SINX) ? ang_q + 12'd1024 : ang_q;

  assign prod = (state_q == ST_MULX) ? dx_q * $signed({1'b0, step_q})
                                     : dy_q * $signed({1'b0, step_q});

  // Column share of the field of view: column * fov / SCREEN_COLUMNS.
  assign share_prod = (2*NUM_W+1)'(numa_q) * (2*NUM_W+1)'(RECIP);

  grm_sine_rom u_rom (
    .clk_i   (clk_i),
    .angle_i (rom_ang),
    .sin_o   (rom_sin)
  );

  // The divider produces the wall height after a hit at a nonzero distance.
  always_comb begin
    div_req.start = (state_q == ST_READ) && (rd_q != 3'd0) && (dist_q != '0);
    div_req.num   = {scrh_q, 10'd0};
    div_den       = dist_q;
  end

  grm_div #(.DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Single write port: clearing pass, cell writes, shot marks.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = AW'(int'(cell_y_i) * GRID_SIZE + int'(cell_x_i));
    mem_wd = cell_value_i;
    mem_ra = cell_addr;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = 3'd0;
    end else if (state_q == ST_IDLE) begin
      mem_we = in_acc && (mode_i == MODE_WRITE) && wr_in_range;
    end else if (state_q == ST_READ) begin
      mem_we = (rd_q != 3'd0) && (mode_q == MODE_SHOT);
      mem_wa = addr_q;
      mem_wd = mark_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    rd_q <= grid_mem[mem_ra];
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q  <= 12'd819;
      step_q <= 10'd102;
      mapw_q <= 6'd30;
      maph_q <= 6'd30;
      scrh_q <= 12'd480;
      mark_q <= 3'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FOV:   fov_q  <= cfg_data_i;
        REG_STEP:  step_q <= cfg_data_i[9:0];
        REG_MAP_W: mapw_q <= cfg_data_i[5:0];
        REG_MAP_H: maph_q <= cfg_data_i[5:0];
        REG_SCR_H: scrh_q <= cfg_data_i;
        REG_MARK:  mark_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer and result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (mode_i == MODE_CAST) begin
              state_q <= ST_DIVA;
            end else if (mode_i == MODE_SHOT) begin
              state_q <= ST_SINX;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
        end
        ST_DIVA:  state_q <= ST_SINX;
        ST_SINX:  state_q <= ST_SINY;
        ST_SINY:  state_q <= ST_MULX;
        ST_MULX:  state_q <= ST_MULY;
        ST_MULY:  state_q <= ST_STEP;
        ST_STEP:  state_q <= ST_CHECK;
        ST_CHECK: begin
          if (oob) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_q != 3'd0) begin
            if (dist_q == '0) begin
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_DIVW;
            end
          end else if (cnt_q == SW'(MAX_STEPS)) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= ST_STEP;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q     <= mode_i;
          px_q       <= pos_x_i;
          py_q       <= pos_y_i;
          view_q     <= view_angle_i;
          ang_q      <= view_angle_i;
          numa_q     <= NUM_W'(column_i) * NUM_W'(fov_q);
          // Write words and unused codes report all zero.
          hit_q      <= 1'b0;
          hx_q       <= '0;
          hy_q       <= '0;
          hv_q       <= '0;
          dist_out_q <= '0;
          wall_q     <= '0;
        end
      end
      ST_DIVA: begin
        ang_q <= view_q - {1'b0, fov_q[11:1]} + share_prod[RS +: 12];
      end
      ST_SINY: dx_q <= rom_sin;
      ST_MULX: begin
        dy_q  <= rom_sin;
        ddx_q <= FW'(prod);
      end
      ST_MULY: begin
        ddy_q  <= FW'(prod);
        fx_q   <= $signed(FW'({px_q, 14'd0}));
        fy_q   <= $signed(FW'({py_q, 14'd0}));
        dist_q <= '0;
        cnt_q  <= '0;
      end
      ST_STEP: begin
        // Advance one step.
        fx_q   <= fx_q + ddx_q;
        fy_q   <= fy_q + ddy_q;
        dist_q <= dist_q + DW'(step_q);
        cnt_q  <= cnt_q + 1'b1;
      end
      ST_CHECK: begin
        addr_q <= cell_addr;
        cx_q   <= fx_q[28:24];
        cy_q   <= fy_q[28:24];
      end
      ST_READ: begin
        val_q <= rd_q;
        if (rd_q != 3'd0) begin
          hit_q      <= 1'b1;
          hx_q       <= cx_q;
          hy_q       <= cy_q;
          hv_q       <= rd_q;
          dist_out_q <= (dist_q > DW'(65535)) ? 16'hFFFF : 16'(dist_q);
          wall_q     <= 12'd4095;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          wall_q <= (div_quot > NUM_W'(4095)) ? 12'd4095 : div_quot[11:0];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign hit_x_o       = hx_q;
  assign hit_y_o       = hy_q;
  assign hit_value_o   = hv_q & val_q | hv_q;
  assign distance_o    = dist_out_q;
  assign wall_height_o = wall_q;

endmodule

// ===== sv/grm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// grm_sine_rom
// Registered Q1.14 sine lookup over a 4096-step circle, quarter-wave table.
// ----------------------------------------------------------------------------
module grm_sine_rom (
  input  logic               clk_i,
  input  logic [11:0]        angle_i,
  output logic signed [15:0] sin_o
);
  typedef logic [14:0] rom_t [1025];

  function automatic logic [14:0] quarter_value(input int k);
    logic [63:0] x, x2, term, pos, neg, s, r;
    x    = (64'(k) * 64'd421657428) >> 10;
    x2   = (x * x) >> 28;
    term = x;
    pos  = x;
    neg  = '0;
    term = ((term * x2) >> 28) / 64'd6;
    neg  = neg + term;
    term = ((term * x2) >> 28) / 64'd20;
    pos  = pos + term;
    term = ((term * x2) >> 28) / 64'd42;
    neg  = neg + term;
    term = ((term * x2) >> 28) / 64'd72;
    pos  = pos + term;
    term = ((term * x2) >> 28) / 64'd110;
    neg  = neg + term;
    if (neg > pos) begin
      return '0;
    end
    s = pos - neg;
    r = (s + 64'd8192) >> 14;
    if (r > 64'd16384) begin
      r = 64'd16384;
    end
    return r[14:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < 1025; k++) begin
      t[k] = quarter_value(k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [10:0] idx;
  logic [14:0] mag_q;
  logic        neg_q;

  // Mirror odd quadrants, negate the lower half circle.
  always_comb begin
    if (angle_i[10]) begin
      idx = 11'd1024 - {1'b0, angle_i[9:0]};
    end else begin
      idx = {1'b0, angle_i[9:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= SINE_ROM[idx];
    neg_q <= angle_i[11];
  end

  assign sin_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

// ===== sv/grm_div.sv =====
// ----------------------------------------------------------------------------
// grm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grm_div #(
  parameter int DW = 19
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  grm_pkg::div_req_t        req_i,
  input  logic [DW-1:0]            den_i,
  output logic                     done_o,
  output logic [grm_pkg::NUM_W-1:0] quot_o
);
  import grm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, quot_q;
  logic [DW-1:0]    den_q;
  logic [DW:0]      rem_q, rem_sh, rem_d;
  logic             ge;

  assign rem_sh = {rem_q[DW-1:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.num;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== sv/grm_checker.sv =====
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks of the ray marcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic [4:0]  hit_x_o,
  input logic [4:0]  hit_y_o,
  input logic [2:0]  hit_value_o,
  input logic [15:0] distance_o,
  input logic [11:0] wall_height_o
);

  `GRM_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |-> !out_valid_o, "result word during reset")
  `GRM_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "input not held off")
  `GRM_ASSERT(a_one_in_flight, out_valid_o |-> in_stall_o, "input open with result pending")
  `GRM_ASSERT(a_miss_is_zero, out_valid_o && !hit_o |-> hit_x_o == 5'd0 && hit_y_o == 5'd0 && hit_value_o == 3'd0 && distance_o == 16'd0 && wall_height_o == 12'd0, "miss word not zero")
  `GRM_ASSERT(a_hold_stalled, out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o) && $stable(wall_height_o), "stalled result changed")

endmodule

bind grid_ray_march grm_checker u_grm_checker (.*);
